// File: rtl/core/ryc_pkg.sv
// ----------------------------------------------------------------------------
// ryc_pkg
// Shared types, constants and color math for the rgb to 4:2:0 converter.
// ----------------------------------------------------------------------------
package ryc_pkg;

  localparam int MaxWidthDefault = 4096;
  localparam int MaxHeight       = 4096;
  localparam int RowW            = 12;
  localparam int CfgIdxW         = 2;
  localparam int CfgDataW        = 13;
  localparam int ResetWidth      = 1280;
  localparam int ResetHeight     = 720;

  localparam int CompN   = 3;
  localparam int PixW    = 8;
  localparam int PairW   = 9;
  localparam int EntryW  = CompN * PairW;

  localparam int CompRed   = 2;
  localparam int CompGreen = 1;
  localparam int CompBlue  = 0;

  localparam int CoefYR    = 66;
  localparam int CoefYG    = 129;
  localparam int CoefYB    = 25;
  localparam int CoefCbR   = 38;
  localparam int CoefCbG   = 74;
  localparam int CoefCbB   = 112;
  localparam int CoefCrR   = 112;
  localparam int CoefCrG   = 94;
  localparam int CoefCrB   = 18;
  localparam int RoundHalf = 128;
  localparam int LumaOff   = 16;
  localparam int LumaMax   = 235;
  localparam int ChromaMin = 16;
  localparam int ChromaMax = 240;
  localparam int ChromaBias = RoundHalf + 256 * 128;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef logic [CompN-1:0][PixW-1:0]  rgb_t;
  typedef logic [CompN-1:0][PairW-1:0] pair_sum_t;

  typedef struct packed {
    logic odd_col;
    logic odd_row;
    logic last_col;
    logic last_row;
  } pos_flags_t;

  function automatic logic [PixW-1:0] luma_of(input rgb_t px);
    logic [15:0] acc;
    logic [8:0]  y;
    acc = 16'(CoefYR * int'(px[CompRed]) + CoefYG * int'(px[CompGreen])
              + CoefYB * int'(px[CompBlue]) + RoundHalf);
    y = {1'b0, acc[15:8]} + 9'(LumaOff);
    if (y > 9'(LumaMax)) begin
      y = 9'(LumaMax);
    end
    return y[PixW-1:0];
  endfunction

  function automatic logic [PixW-1:0] chroma_clamp(input logic [16:0] acc);
    logic [PixW-1:0] v;
    v = acc[15:8];
    if (v < 8'(ChromaMin)) begin
      v = 8'(ChromaMin);
    end else if (v > 8'(ChromaMax)) begin
      v = 8'(ChromaMax);
    end
    return v;
  endfunction

  function automatic logic [PixW-1:0] chroma_blue_of(input rgb_t avg);
    logic [16:0] acc;
    acc = 17'(ChromaBias + CoefCbB * int'(avg[CompBlue])
              - CoefCbR * int'(avg[CompRed]) - CoefCbG * int'(avg[CompGreen]));
    return chroma_clamp(acc);
  endfunction

  function automatic logic [PixW-1:0] chroma_red_of(input rgb_t avg);
    logic [16:0] acc;
    acc = 17'(ChromaBias + CoefCrR * int'(avg[CompRed])
              - CoefCrG * int'(avg[CompGreen]) - CoefCrB * int'(avg[CompBlue]));
    return chroma_clamp(acc);
  endfunction

endpackage

// File: rtl/core/ryc_pixel_if.sv
// ----------------------------------------------------------------------------
// ryc_pixel_if
// Valid/ready channel carrying one rgb pixel per transfer.
// ----------------------------------------------------------------------------
interface ryc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

// File: rtl/core/ryc_result_if.sv
// ----------------------------------------------------------------------------
// ryc_result_if
// Valid/ready channel carrying luma, block chroma and frame end per transfer.
// ----------------------------------------------------------------------------
interface ryc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic       chroma_valid;
  logic [7:0] chroma_blue;
  logic [7:0] chroma_red;
  logic       frame_done;

  modport source (output valid, luma, chroma_valid, chroma_blue, chroma_red, frame_done,
                  input ready);
  modport sink   (input valid, luma, chroma_valid, chroma_blue, chroma_red, frame_done,
                  output ready);
endinterface

// File: rtl/core/ryc_line_store.sv
// ----------------------------------------------------------------------------
// ryc_line_store
// Simple dual port line memory holding even row pair sums, registered read.
// ----------------------------------------------------------------------------
module ryc_line_store
  import ryc_pkg::*;
#(
  parameter int DEPTH  = MaxWidthDefault / 2,
  parameter int ADDR_W = $clog2(MaxWidthDefault / 2)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  pair_sum_t            wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output pair_sum_t            rd_data
);

  pair_sum_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/ryc_ctrl.sv
// ----------------------------------------------------------------------------
// ryc_ctrl
// Frame size registers and raster position counters.
// ----------------------------------------------------------------------------
module ryc_ctrl
  import ryc_pkg::*;
#(
  parameter int MAX_WIDTH = MaxWidthDefault,
  parameter int SLOT_W    = $clog2(MaxWidthDefault / 2)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                step,
  output pos_flags_t          flags,
  output logic [SLOT_W-1:0]   slot
);

  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ResetLastCol = ((ResetWidth > MAX_WIDTH) ? MAX_WIDTH : ResetWidth) - 1;
  localparam int ResetLastRow = ((ResetHeight > MaxHeight) ? MaxHeight : ResetHeight) - 1;

  logic [ColW-1:0] col, col_next;
  logic [RowW-1:0] row, row_next;
  logic [ColW-1:0] last_col_idx, last_col_idx_next;
  logic [RowW-1:0] last_row_idx, last_row_idx_next;
  logic            restart;

  always_comb begin
    if (cfg_data == '0) begin
      last_col_idx_next = '0;
    end else if (int'(cfg_data) > MAX_WIDTH) begin
      last_col_idx_next = ColW'(MAX_WIDTH - 1);
    end else begin
      last_col_idx_next = ColW'(cfg_data - 1'b1);
    end
    if (cfg_data == '0) begin
      last_row_idx_next = '0;
    end else if (int'(cfg_data) > MaxHeight) begin
      last_row_idx_next = RowW'(MaxHeight - 1);
    end else begin
      last_row_idx_next = RowW'(cfg_data - 1'b1);
    end
  end

  always_comb begin
    restart = 1'b0;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  restart = 1'b1;
        REG_FRAME_HEIGHT: restart = 1'b1;
        default:          restart = 1'b0;
      endcase
    end
  end

  always_comb begin
    flags.odd_col  = col[0];
    flags.odd_row  = row[0];
    flags.last_col = (col == last_col_idx);
    flags.last_row = (row == last_row_idx);
    slot           = SLOT_W'(col >> 1);
  end

  always_comb begin
    col_next = col;
    row_next = row;
    if (restart) begin
      col_next = '0;
      row_next = '0;
    end else if (step) begin
      if (flags.last_col) begin
        col_next = '0;
        row_next = flags.last_row ? '0 : row + 1'b1;
      end else begin
        col_next = col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col          <= '0;
      row          <= '0;
      last_col_idx <= ColW'(ResetLastCol);
      last_row_idx <= RowW'(ResetLastRow);
    end else begin
      col <= col_next;
      row <= row_next;
      if (cfg_wr_en && cfg_index == REG_FRAME_WIDTH) begin
        last_col_idx <= last_col_idx_next;
      end
      if (cfg_wr_en && cfg_index == REG_FRAME_HEIGHT) begin
        last_row_idx <= last_row_idx_next;
      end
    end
  end

endmodule

// File: rtl/core/ryc_pipe.sv
// ----------------------------------------------------------------------------
// ryc_pipe
// Three stage pixel pipeline: pair sums and line store read-modify-write,
// color matrix, result register.
// ----------------------------------------------------------------------------
module ryc_pipe
  import ryc_pkg::*;
#(
  parameter int SLOT_W = $clog2(MaxWidthDefault / 2)
) (
  input  logic                clk,
  input  logic                rst,
  ryc_pixel_if.sink           pixel,
  ryc_result_if.source        result,
  input  pos_flags_t          flags,
  input  logic [SLOT_W-1:0]   slot,
  output logic                step,
  output logic                mem_wr_en,
  output logic [SLOT_W-1:0]   mem_wr_addr,
  output pair_sum_t           mem_wr_data,
  output logic                mem_rd_en,
  output logic [SLOT_W-1:0]   mem_rd_addr,
  input  pair_sum_t           mem_rd_data
);

  // stage a
  logic              a_valid;
  rgb_t              a_px;
  pos_flags_t        a_flags;
  logic [SLOT_W-1:0] a_slot;
  logic              a_fwd;
  logic              a_ready, a_leave, a_pair_end, a_cvalid;
  rgb_t              pair_first;
  pair_sum_t         wr_hold;
  pair_sum_t         a_psum, a_even;
  rgb_t              a_avg;

  // stage b
  logic              b_valid;
  rgb_t              b_px;
  rgb_t              b_avg;
  logic              b_cvalid, b_done;
  logic              b_ready, b_leave;

  // result register
  logic              c_valid;
  logic [PixW-1:0]   c_luma, c_cb, c_cr;
  logic              c_cvalid, c_done;
  logic              c_ready;

  logic              fwd_next;

  assign c_ready = !c_valid || result.ready;
  assign b_ready = !b_valid || c_ready;
  assign a_ready = !a_valid || b_ready;
  assign b_leave = b_valid && c_ready;
  assign a_leave = a_valid && b_ready;

  assign pixel.ready = a_ready;
  assign step        = pixel.valid && a_ready;

  assign mem_rd_en   = step;
  assign mem_rd_addr = slot;

  assign a_pair_end  = a_flags.odd_col || a_flags.last_col;
  assign a_cvalid    = a_pair_end && (a_flags.odd_row || a_flags.last_row);

  assign mem_wr_en   = a_leave && a_pair_end && !a_flags.odd_row;
  assign mem_wr_addr = a_slot;
  assign mem_wr_data = a_psum;

  // the entry written this cycle is not yet visible to a read issued now
  assign fwd_next = mem_wr_en && (mem_wr_addr == slot);

  always_comb begin
    logic [PairW:0] tot;
    logic [PairW:0] rnd;
    a_even = a_fwd ? wr_hold : mem_rd_data;
    for (int k = 0; k < CompN; k++) begin
      if (a_flags.odd_col) begin
        a_psum[k] = PairW'(pair_first[k]) + PairW'(a_px[k]);
      end else begin
        a_psum[k] = {a_px[k], 1'b0};
      end
      if (a_flags.odd_row) begin
        tot = (PairW+1)'(a_psum[k]) + (PairW+1)'(a_even[k]);
      end else begin
        tot = {a_psum[k], 1'b0};
      end
      rnd = tot + (PairW+1)'(2);
      a_avg[k] = rnd[PairW:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      pair_first <= '0;
    end else begin
      if (a_ready) begin
        a_valid <= pixel.valid;
      end
      if (a_leave && !a_pair_end) begin
        pair_first <= a_px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      a_px[CompRed]   <= pixel.pixel_red;
      a_px[CompGreen] <= pixel.pixel_green;
      a_px[CompBlue]  <= pixel.pixel_blue;
      a_flags         <= flags;
      a_slot          <= slot;
      a_fwd           <= fwd_next;
    end
    if (mem_wr_en) begin
      wr_hold <= mem_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_leave) begin
      b_px     <= a_px;
      b_avg    <= a_avg;
      b_cvalid <= a_cvalid;
      b_done   <= a_flags.last_col && a_flags.last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_leave) begin
      c_luma   <= luma_of(b_px);
      c_cvalid <= b_cvalid;
      c_cb     <= b_cvalid ? chroma_blue_of(b_avg) : '0;
      c_cr     <= b_cvalid ? chroma_red_of(b_avg) : '0;
      c_done   <= b_done;
    end
  end

  assign result.valid        = c_valid;
  assign result.luma         = c_luma;
  assign result.chroma_valid = c_cvalid;
  assign result.chroma_blue  = c_cb;
  assign result.chroma_red   = c_cr;
  assign result.frame_done   = c_done;

endmodule

// File: rtl/core/rgb_to_yuv420_converter_core.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_core
// Streaming rgb to studio-range 4:2:0 luma/chroma converter.
//
//   channel   dir   handshake      payload
//   pixel     in    valid/ready    pixel_red, pixel_green, pixel_blue
//   result    out   valid/ready    luma, chroma_valid, chroma_blue, chroma_red,
//                                  frame_done
//   cfg       in    cfg_wr_en      cfg_index, cfg_data
//
// One pixel per cycle sustained while results are taken; after its transfer a
// pixel passes stage a, stage b and the result register before it leaves.
// The line store has one write and one read port; a write and a read of the
// same entry in one cycle are resolved by forwarding.
// Reset is synchronous; the line store needs no clearing pass.
// A stalled result holds its register; pixels keep being taken until all
// three stages are full.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter_core
  import ryc_pkg::*;
#(
  parameter int MAX_WIDTH = MaxWidthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  ryc_pixel_if.sink           pixel,
  ryc_result_if.source        result
);

  localparam int PairSlots = (MAX_WIDTH + 1) / 2;
  localparam int SlotW     = (PairSlots > 1) ? $clog2(PairSlots) : 1;

  pos_flags_t       flags;
  logic [SlotW-1:0] slot;
  logic             step;
  logic             mem_wr_en, mem_rd_en;
  logic [SlotW-1:0] mem_wr_addr, mem_rd_addr;
  pair_sum_t        mem_wr_data, mem_rd_data;

  ryc_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .SLOT_W    (SlotW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .flags     (flags),
    .slot      (slot)
  );

  ryc_line_store #(
    .DEPTH  (PairSlots),
    .ADDR_W (SlotW)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  ryc_pipe #(
    .SLOT_W (SlotW)
  ) u_pipe (
    .clk         (clk),
    .rst         (rst),
    .pixel       (pixel),
    .result      (result),
    .flags       (flags),
    .slot        (slot),
    .step        (step),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

endmodule

// File: rtl/core/ryc_checker.sv
// ----------------------------------------------------------------------------
// ryc_checker
// Port level checks for the converter core, bound to the top level.
// ----------------------------------------------------------------------------
module ryc_checker (
  input logic       clk,
  input logic       rst,
  input logic       pix_valid,
  input logic       pix_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] luma,
  input logic       chroma_valid,
  input logic [7:0] chroma_blue,
  input logic [7:0] chroma_red,
  input logic       frame_done
);

  logic       pix_acc, res_acc;
  logic [1:0] inflight;

  assign pix_acc = pix_valid && pix_ready;
  assign res_acc = res_valid && res_ready;

  // items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 2'(pix_acc) - 2'(res_acc);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(luma) && $stable(chroma_valid)
      && $stable(chroma_blue) && $stable(chroma_red) && $stable(frame_done))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> inflight != 2'd0)
    else $error("result without a pixel");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    inflight == 2'd3 && pix_acc |-> res_acc)
    else $error("pixel taken with all stages full");

  a_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !chroma_valid |-> chroma_blue == 8'd0 && chroma_red == 8'd0)
    else $error("chroma set without a block");

  a_luma_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> luma >= 8'd16 && luma <= 8'd235)
    else $error("luma out of range");

endmodule

bind rgb_to_yuv420_converter_core ryc_checker u_ryc_checker (
  .clk          (clk),
  .rst          (rst),
  .pix_valid    (pixel.valid),
  .pix_ready    (pixel.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .luma         (result.luma),
  .chroma_valid (result.chroma_valid),
  .chroma_blue  (result.chroma_blue),
  .chroma_red   (result.chroma_red),
  .frame_done   (result.frame_done)
);

// File: tb/rgb_to_yuv420_converter_core_tb.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_core_tb
// Streams rgb pixels through the converter over many frame sizes, including
// odd, zero and oversized ones, and checks every luma/chroma/frame-end result
// in order against a behavioral copy of the 4:2:0 conversion and its line
// store. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter_core_tb;
  import ryc_pkg::*;

  localparam int MaxW        = MaxWidthDefault;
  localparam int PairSlots   = (MaxW + 1) / 2;
  localparam int RandomItems = 540;
  localparam int LargeItems  = 40;
  localparam int CycleLimit  = 3_000_000;
  localparam int MaxReported = 10;

  localparam logic [CfgIdxW-1:0] RegSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 2'd3;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       frame_done;
  } yuv_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  ryc_pixel_if  pix_ch ();
  ryc_result_if res_ch ();

  rgb_to_yuv420_converter_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pix_ch),
    .result    (res_ch)
  );

  always #5 clk = ~clk;

  // converter state mirror
  logic [CfgDataW-1:0] cfg_width  = CfgDataW'(ResetWidth);
  logic [CfgDataW-1:0] cfg_height = CfgDataW'(ResetHeight);
  int                  next_col   = 0;
  int                  next_row   = 0;
  rgb_t                pair_first = '0;
  pair_sum_t           even_row_sums [PairSlots];

  rgb_t pixel_queue [$];
  yuv_t yuv_expected [$];
  rgb_t next_px;
  int   src_gap_left;
  int   sink_stall_left;
  int   src_idle_pct  = 0;
  int   sink_idle_pct = 0;
  int   mismatches    = 0;
  int   results_seen  = 0;
  int   cycle_count   = 0;

  function automatic logic [7:0] clamp8(input int v, input int lo, input int hi);
    if (v < lo) return 8'(lo);
    if (v > hi) return 8'(hi);
    return 8'(v);
  endfunction

  function automatic yuv_t convert_pixel(input rgb_t px);
    int        w, h, c, rw, slot, k, ar, ag, ab, vb, vr;
    int        s [CompN];
    logic      last_c, last_r;
    pair_sum_t e;
    yuv_t      o;
    w = (cfg_width == 0) ? 1 : int'(cfg_width);
    if (w > MaxW) w = MaxW;
    h = (cfg_height == 0) ? 1 : int'(cfg_height);
    if (h > MaxHeight) h = MaxHeight;
    c  = (next_col >= w) ? w - 1 : next_col;
    rw = (next_row >= h) ? h - 1 : next_row;
    last_c = (c == w - 1);
    last_r = (rw == h - 1);
    slot = (c / 2) % PairSlots;
    o = '0;
    o.luma = clamp8(((66 * int'(px[CompRed]) + 129 * int'(px[CompGreen])
                      + 25 * int'(px[CompBlue]) + 128) >> 8) + 16, 16, 235);
    if ((c % 2 == 1) || last_c) begin
      for (k = 0; k < CompN; k++) begin
        s[k] = (c % 2 == 1) ? int'(pair_first[k]) + int'(px[k]) : 2 * int'(px[k]);
      end
      if (rw % 2 == 0) begin
        for (k = 0; k < CompN; k++) e[k] = 9'(s[k]);
        even_row_sums[slot] = e;
        if (last_r) begin
          for (k = 0; k < CompN; k++) s[k] = 2 * s[k];
          o.chroma_valid = 1'b1;
        end
      end else begin
        for (k = 0; k < CompN; k++) s[k] = s[k] + int'(even_row_sums[slot][k]);
        o.chroma_valid = 1'b1;
      end
    end else begin
      pair_first = px;
    end
    if (o.chroma_valid) begin
      ar = (s[CompRed] + 2) >> 2;
      ag = (s[CompGreen] + 2) >> 2;
      ab = (s[CompBlue] + 2) >> 2;
      // offset keeps the sums positive so the shift floors
      vb = -38 * ar - 74 * ag + 112 * ab + 128 + 32768;
      vr = 112 * ar - 94 * ag - 18 * ab + 128 + 32768;
      o.chroma_blue = clamp8(vb >> 8, 16, 240);
      o.chroma_red  = clamp8(vr >> 8, 16, 240);
    end
    o.frame_done = last_c && last_r;
    if (last_c) begin
      next_col = 0;
      next_row = last_r ? 0 : rw + 1;
    end else begin
      next_col = c + 1;
      next_row = rw;
    end
    return o;
  endfunction

  function automatic int draw_gap(input int idle_pct);
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 24);
    return $urandom_range(1, 3);
  endfunction

  function automatic int draw_idle_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic rgb_t draw_pixel(input bit saturated);
    rgb_t p;
    int   k;
    for (k = 0; k < CompN; k++) begin
      if (saturated) p[k] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      else case ($urandom_range(0, 7))
        0: p[k] = 8'h00;
        1: p[k] = 8'hff;
        default: p[k] = 8'($urandom);
      endcase
    end
    return p;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      pix_ch.valid <= 1'b0;
      src_gap_left <= 0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        yuv_expected.push_back(convert_pixel({pix_ch.pixel_red, pix_ch.pixel_green,
                                              pix_ch.pixel_blue}));
      end
      if (!pix_ch.valid || pix_ch.ready) begin
        if (src_gap_left > 0) begin
          pix_ch.valid <= 1'b0;
          src_gap_left <= src_gap_left - 1;
        end else if (pixel_queue.size() != 0) begin
          next_px = pixel_queue.pop_front();
          pix_ch.valid       <= 1'b1;
          pix_ch.pixel_red   <= next_px[CompRed];
          pix_ch.pixel_green <= next_px[CompGreen];
          pix_ch.pixel_blue  <= next_px[CompBlue];
          src_gap_left <= draw_gap(src_idle_pct);
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready    <= 1'b0;
      sink_stall_left <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen <= results_seen + 1;
        if (yuv_expected.size() == 0) begin
          if (mismatches < MaxReported) begin
            $display("unexpected result %0d: luma=%0d cv=%0b cb=%0d cr=%0d fd=%0b",
                     results_seen, res_ch.luma, res_ch.chroma_valid, res_ch.chroma_blue,
                     res_ch.chroma_red, res_ch.frame_done);
          end
          mismatches <= mismatches + 1;
        end else if ({res_ch.luma, res_ch.chroma_valid, res_ch.chroma_blue,
                      res_ch.chroma_red, res_ch.frame_done} !== yuv_expected[0]) begin
          if (mismatches < MaxReported) begin
            $display({"mismatch at result %0d: expected luma=%0d cv=%0b cb=%0d cr=%0d ",
                      "fd=%0b, got luma=%0d cv=%0b cb=%0d cr=%0d fd=%0b"},
                     results_seen, yuv_expected[0].luma, yuv_expected[0].chroma_valid,
                     yuv_expected[0].chroma_blue, yuv_expected[0].chroma_red,
                     yuv_expected[0].frame_done, res_ch.luma, res_ch.chroma_valid,
                     res_ch.chroma_blue, res_ch.chroma_red, res_ch.frame_done);
          end
          mismatches <= mismatches + 1;
          void'(yuv_expected.pop_front());
        end else begin
          void'(yuv_expected.pop_front());
        end
      end
      if (sink_stall_left > 0) begin
        res_ch.ready    <= 1'b0;
        sink_stall_left <= sink_stall_left - 1;
      end else if (draw_gap(sink_idle_pct) > 0) begin
        res_ch.ready    <= 1'b0;
        sink_stall_left <= draw_gap(sink_idle_pct);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || pix_ch.valid || yuv_expected.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataW'(val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
      if (idx == REG_FRAME_WIDTH) cfg_width = CfgDataW'(val);
      else cfg_height = CfgDataW'(val);
      next_col = 0;
      next_row = 0;
    end
    @(negedge clk);
  endtask

  task automatic run_pixels(input int count, input bit saturated);
    repeat (count) pixel_queue.push_back(draw_pixel(saturated));
    wait_idle();
  endtask

  initial begin
    int w, h, n, random_sent;
    cfg_wr_en          = 1'b0;
    cfg_index          = REG_FRAME_WIDTH;
    cfg_data           = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.pixel_red   = '0;
    pix_ch.pixel_green = '0;
    pix_ch.pixel_blue  = '0;
    res_ch.ready       = 1'b0;
    random_sent        = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset frame size, first row only
    pixel_queue.push_back({8'd0, 8'd0, 8'd0});
    pixel_queue.push_back({8'd255, 8'd255, 8'd255});
    pixel_queue.push_back({8'd255, 8'd0, 8'd0});
    pixel_queue.push_back({8'd0, 8'd255, 8'd0});
    pixel_queue.push_back({8'd0, 8'd0, 8'd255});
    pixel_queue.push_back({8'd128, 8'd127, 8'd1});
    wait_idle();

    // 3x3: odd width and odd height, clamped chroma, then wrap into next frame
    src_idle_pct  = 30;
    sink_idle_pct = 30;
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    pixel_queue.push_back({8'd0, 8'd0, 8'd255});
    pixel_queue.push_back({8'd0, 8'd0, 8'd255});
    pixel_queue.push_back({8'd255, 8'd0, 8'd0});
    pixel_queue.push_back({8'd0, 8'd0, 8'd255});
    pixel_queue.push_back({8'd0, 8'd0, 8'd255});
    pixel_queue.push_back({8'd255, 8'd0, 8'd0});
    pixel_queue.push_back({8'd0, 8'd255, 8'd0});
    pixel_queue.push_back({8'd255, 8'd255, 8'd255});
    pixel_queue.push_back({8'd0, 8'd0, 8'd0});
    pixel_queue.push_back({8'd0, 8'd255, 8'd255});
    pixel_queue.push_back({8'd255, 8'd0, 8'd255});
    wait_idle();

    // writes to spare indices leave the frame position alone
    write_reg(RegSpareLo, 8191);
    write_reg(RegSpareHi, 0);
    pixel_queue.push_back({8'd255, 8'd255, 8'd0});
    pixel_queue.push_back({8'd0, 8'd255, 8'd255});
    pixel_queue.push_back({8'd255, 8'd0, 8'd255});
    pixel_queue.push_back({8'd10, 8'd200, 8'd90});
    wait_idle();

    // zero size acts as 1x1
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 0);
    pixel_queue.push_back({8'd255, 8'd255, 8'd255});
    pixel_queue.push_back({8'd0, 8'd0, 8'd0});
    pixel_queue.push_back({8'd255, 8'd0, 8'd0});
    wait_idle();

    while (random_sent < RandomItems) begin
      src_idle_pct  = draw_idle_pct();
      sink_idle_pct = draw_idle_pct();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: w = $urandom_range(1, 8);
        7, 8: w = $urandom_range(9, 40);
        default: w = $urandom_range(41, 200);
      endcase
      h = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 12);
      case ($urandom_range(0, 3))
        0: ;
        1: begin
          write_reg(REG_FRAME_WIDTH, w);
          write_reg(REG_FRAME_HEIGHT, h);
        end
        default: begin
          write_reg(REG_FRAME_HEIGHT, h);
          write_reg(REG_FRAME_WIDTH, w);
        end
      endcase
      n = $urandom_range(1, 2 * w * h + 2);
      if (n > 150) n = 150;
      run_pixels(n, $urandom_range(0, 4) == 0);
      random_sent += n;
    end

    // largest sizes
    src_idle_pct  = 10;
    sink_idle_pct = 10;
    write_reg(REG_FRAME_WIDTH, MaxW);
    write_reg(REG_FRAME_HEIGHT, 8191);
    run_pixels(LargeItems, 1'b0);
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, MaxHeight);
    run_pixels(LargeItems, 1'b0);
    write_reg(REG_FRAME_WIDTH, 8191);
    write_reg(REG_FRAME_HEIGHT, 1);
    run_pixels(LargeItems, 1'b0);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    repeat (16) @(posedge clk);
    if (mismatches == 0 && yuv_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
